// ===== rtl/core/frt_pkg.sv =====
// Package for the frame reference count table: codes, state encoding and defaults.
// Used by rtl/core/frame_refcount_table_unit.sv; depends on nothing else.
package frt_pkg;

  localparam int unsigned FRAME_COUNT_DEF = 4096;
  localparam int unsigned PAGE_SHIFT_DEF  = 12;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned CFG_W   = 13;
  // Wide enough for a rounded-up end frame and any frame limit.
  localparam int unsigned CMP_W   = 34;

  localparam logic [2:0] ACT_CLAIM   = 3'd0;
  localparam logic [2:0] ACT_RELEASE = 3'd1;
  localparam logic [2:0] ACT_ADDREF  = 3'd2;
  localparam logic [2:0] ACT_READ    = 3'd3;
  localparam logic [2:0] ACT_RESERVE = 3'd4;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RANGE     = 3'd1,
    ST_DOUBLE    = 3'd2,
    ST_NOT_FREE  = 3'd3,
    ST_FREE      = 3'd4,
    ST_OVERFLOW  = 3'd5,
    ST_BAD_RANGE = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MODIFY,
    S_RESERVE,
    S_DONE
  } state_e;

endpackage

// ===== rtl/core/frame_refcount_table_unit.sv =====
// Frame reference count table: one count memory under a small sequencer.
// Depends on rtl/core/frt_pkg.sv.
//
//   channel | direction | handshake                  | word
//   cfg     | in        | cfg_we_i                   | cfg_frames_managed_i
//   in      | in        | in_valid_i / in_ready_o    | action_i, address_i, end_address_i
//   out     | out       | out_valid_o / out_ready_i  | count_o, status_o, frame_released_o
//
// Claim, release, add reference and read: the accept cycle reads the count memory and
// S_MODIFY then modifies, writes back and loads the output. Range errors go to S_DONE.
// A reserve of N frames walks them one frame per cycle through the memory port.
// After reset a clearing pass writes zero to all FRAME_COUNT entries, one per cycle,
// and no word is accepted until it ends. A word is accepted while a result waits; the
// block holds in its final step until the output register is free.
module frame_refcount_table_unit
  import frt_pkg::*;
#(
  parameter int unsigned FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int unsigned PAGE_SHIFT  = PAGE_SHIFT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_frames_managed_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         action_i,
  input  logic [ADDR_W-1:0]  address_i,
  input  logic [ADDR_W-1:0]  end_address_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [COUNT_W-1:0] count_o,
  output logic [2:0]         status_o,
  output logic               frame_released_o
);

  localparam int unsigned IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam logic [ADDR_W:0] PAGE_MASK = (ADDR_W + 1)'((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_COUNT - 1);
  localparam logic [CMP_W-1:0] FRAME_COUNT_C = CMP_W'(FRAME_COUNT);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  logic [COUNT_W-1:0] mem [FRAME_COUNT];

  state_e             state_q, state_d;
  logic [CFG_W-1:0]   cfg_q;
  logic [2:0]         act_q, act_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [CMP_W-1:0]   last_q, last_d;
  status_e            res_q, res_d;
  logic [COUNT_W-1:0] rdata_q;

  logic               out_valid_q, out_valid_d;
  logic [COUNT_W-1:0] out_count_q, out_count_d;
  status_e            out_status_q, out_status_d;
  logic               out_rel_q, out_rel_d;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa, mem_ra;
  logic [COUNT_W-1:0] mem_wd;

  logic [CMP_W-1:0]   limit, in_frame, in_last, in_last_c;
  logic [ADDR_W:0]    end_round;
  logic               out_free;

  assign limit     = (CMP_W'(cfg_q) > FRAME_COUNT_C) ? FRAME_COUNT_C : CMP_W'(cfg_q);
  assign in_frame  = CMP_W'(address_i >> PAGE_SHIFT);
  assign end_round = (ADDR_W + 1)'(end_address_i) + PAGE_MASK;
  assign in_last   = CMP_W'(end_round >> PAGE_SHIFT);
  assign in_last_c = (in_last > limit) ? limit : in_last;
  assign out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cfg_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_frames_managed_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    last_q       <= last_d;
    res_q        <= res_d;
    out_count_q  <= out_count_d;
    out_status_q <= out_status_d;
    out_rel_q    <= out_rel_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[mem_ra];
  end

  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    idx_d        = idx_q;
    last_d       = last_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_count_d  = out_count_q;
    out_status_d = out_status_q;
    out_rel_d    = out_rel_q;
    mem_we       = 1'b0;
    mem_wa       = idx_q;
    mem_wd       = '0;
    mem_ra       = idx_q;
    in_ready_o   = 1'b0;

    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        idx_d  = idx_q + 1'b1;
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        // The accept cycle already reads the addressed entry.
        mem_ra     = in_frame[IDX_W-1:0];
        if (in_valid_i) begin
          act_d  = action_i;
          idx_d  = in_frame[IDX_W-1:0];
          last_d = in_last_c;
          res_d  = ST_OK;
          case (action_i)
            ACT_CLAIM, ACT_RELEASE, ACT_ADDREF, ACT_READ: begin
              if (in_frame >= limit) begin
                res_d   = ST_RANGE;
                state_d = S_DONE;
              end else begin
                state_d = S_MODIFY;
              end
            end
            ACT_RESERVE: begin
              if (address_i > end_address_i) begin
                res_d   = ST_BAD_RANGE;
                state_d = S_DONE;
              end else if (address_i == end_address_i || in_frame >= in_last_c) begin
                state_d = S_DONE;
              end else begin
                state_d = S_RESERVE;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_MODIFY: begin
        // The read address stays on the frame so that the data holds during a stall.
        mem_ra = idx_q;
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_count_d  = rdata_q;
          out_status_d = ST_OK;
          out_rel_d    = 1'b0;
          state_d      = S_IDLE;
          case (act_q)
            ACT_CLAIM: begin
              if (rdata_q != '0) begin
                out_status_d = ST_NOT_FREE;
              end else begin
                mem_we      = 1'b1;
                mem_wd      = COUNT_W'(1);
                out_count_d = COUNT_W'(1);
              end
            end
            ACT_RELEASE: begin
              if (rdata_q == '0) begin
                out_status_d = ST_DOUBLE;
              end else begin
                mem_we      = 1'b1;
                mem_wd      = rdata_q - 1'b1;
                out_count_d = rdata_q - 1'b1;
                out_rel_d   = (rdata_q == COUNT_W'(1));
              end
            end
            ACT_ADDREF: begin
              if (rdata_q == '0) begin
                out_status_d = ST_FREE;
              end else if (rdata_q == COUNT_MAX) begin
                out_status_d = ST_OVERFLOW;
              end else begin
                mem_we      = 1'b1;
                mem_wd      = rdata_q + 1'b1;
                out_count_d = rdata_q + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RESERVE: begin
        // Write back the current frame while the next one is being read.
        mem_we = (rdata_q == '0);
        mem_wd = COUNT_W'(1);
        mem_ra = idx_q + 1'b1;
        idx_d  = idx_q + 1'b1;
        if (CMP_W'(idx_q) + CMP_W'(1) >= last_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_count_d  = '0;
          out_status_d = res_q;
          out_rel_d    = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign count_o          = out_count_q;
  assign status_o         = out_status_q;
  assign frame_released_o = out_rel_q;

endmodule

// ===== test/frt_checker.sv =====
// Result checker for the frame reference count table: keeps a shadow copy of the counts,
// predicts every result word and compares it with what the block returns.
// Depends on rtl/core/frt_pkg.sv.
module frt_checker
  import frt_pkg::*;
#(
  parameter int unsigned FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int unsigned PAGE_SHIFT  = PAGE_SHIFT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_frames_managed_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [2:0]         action_i,
  input  logic [ADDR_W-1:0]  address_i,
  input  logic [ADDR_W-1:0]  end_address_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [COUNT_W-1:0] count_i,
  input  logic [2:0]         status_i,
  input  logic               frame_released_i,
  output int unsigned        outstanding_o,
  output int unsigned        mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    status_e            status;
    logic               released;
  } refcount_word_t;

  logic [COUNT_W-1:0] shadow_counts [FRAME_COUNT];
  logic [CFG_W-1:0]   frames_managed;
  refcount_word_t     awaited_words [$];
  int unsigned        waiting_total  = 0;
  int unsigned        mismatch_total = 0;

  assign outstanding_o = waiting_total;
  assign mismatches_o  = mismatch_total;

  function automatic refcount_word_t apply_action(input logic [2:0] act,
                                                  input logic [ADDR_W-1:0] addr,
                                                  input logic [ADDR_W-1:0] end_addr);
    refcount_word_t  res;
    longint unsigned lim;
    longint unsigned frame;
    longint unsigned end_frame;
    lim   = (frames_managed < FRAME_COUNT) ? frames_managed : FRAME_COUNT;
    frame = addr >> PAGE_SHIFT;
    res   = '{'0, ST_OK, 1'b0};
    if (act <= ACT_READ && frame >= lim) begin
      res.status = ST_RANGE;
      return res;
    end
    case (act)
      ACT_CLAIM: begin
        if (shadow_counts[frame] != '0) res.status = ST_NOT_FREE;
        else shadow_counts[frame] = 1;
        res.count = shadow_counts[frame];
      end
      ACT_RELEASE: begin
        if (shadow_counts[frame] == '0) begin
          res.status = ST_DOUBLE;
        end else begin
          shadow_counts[frame] = shadow_counts[frame] - 1;
          res.released = (shadow_counts[frame] == '0);
        end
        res.count = shadow_counts[frame];
      end
      ACT_ADDREF: begin
        if (shadow_counts[frame] == '0) res.status = ST_FREE;
        else if (&shadow_counts[frame]) res.status = ST_OVERFLOW;
        else shadow_counts[frame] = shadow_counts[frame] + 1;
        res.count = shadow_counts[frame];
      end
      ACT_READ: begin
        res.count = shadow_counts[frame];
      end
      ACT_RESERVE: begin
        if (addr > end_addr) begin
          res.status = ST_BAD_RANGE;
        end else if (addr < end_addr) begin
          // The end is rounded up in 64 bits, so the top page of the space is not lost.
          end_frame = (64'(end_addr) + (64'd1 << PAGE_SHIFT) - 1) >> PAGE_SHIFT;
          if (end_frame > lim) end_frame = lim;
          for (longint unsigned f = frame; f < end_frame; f++)
            if (shadow_counts[f] == '0) shadow_counts[f] = 1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] got,
                                 input logic [COUNT_W-1:0] want);
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_total++;
  endtask

  always @(posedge clk_i) begin
    refcount_word_t want;
    if (!rst_ni) begin
      foreach (shadow_counts[i]) shadow_counts[i] = '0;
      frames_managed = '0;
      awaited_words.delete();
    end else begin
      if (cfg_we_i) frames_managed = cfg_frames_managed_i;
      // A result taken at this edge always belongs to an earlier word, so it is checked first.
      if (out_valid_i && out_ready_i) begin
        if (awaited_words.size() == 0) begin
          report_mismatch("result word with none expected", count_i, '0);
        end else begin
          want = awaited_words.pop_front();
          if (count_i !== want.count) report_mismatch("count", count_i, want.count);
          if (status_i !== want.status)
            report_mismatch("status", 32'(status_i), 32'(want.status));
          if (frame_released_i !== want.released)
            report_mismatch("frame_released", 32'(frame_released_i), 32'(want.released));
        end
      end
      if (in_valid_i && in_ready_i)
        awaited_words.push_back(apply_action(action_i, address_i, end_address_i));
    end
    waiting_total <= awaited_words.size();
  end

endmodule

// ===== test/testbench.sv =====
// Top of the frame reference count table testbench: clock, reset, register writes,
// request and result traffic, and the verdict. Depends on rtl/core/frt_pkg.sv,
// rtl/core/frame_refcount_table_unit.sv and test/frt_checker.sv.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import frt_pkg::*;

  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned WORDS_PER_PHASE  = 140;
  localparam int unsigned PAGE_MASK        = (1 << PAGE_SHIFT_DEF) - 1;
  localparam int unsigned PHASES           = 7;
  localparam int unsigned FRAME_PLAN [PHASES] = '{4096, 37, 1, 4095, 0, 200, 4096};

  logic               clk_i                = 1'b0;
  logic               rst_ni               = 1'b0;
  logic               cfg_we_i             = 1'b0;
  logic [CFG_W-1:0]   cfg_frames_managed_i = '0;
  logic               in_valid_i           = 1'b0;
  logic [2:0]         action_i             = ACT_READ;
  logic [ADDR_W-1:0]  address_i            = '0;
  logic [ADDR_W-1:0]  end_address_i        = '0;
  logic               out_ready_i          = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [COUNT_W-1:0] count_o;
  logic [2:0]         status_o;
  logic               frame_released_o;

  int unsigned outstanding;
  int unsigned mismatches;
  int unsigned frames_now = 0;
  bit          hold_req   = 1'b0;
  bit          idle_on    = 1'b1;

  frame_refcount_table_unit dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_frames_managed_i (cfg_frames_managed_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .action_i             (action_i),
    .address_i            (address_i),
    .end_address_i        (end_address_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .count_o              (count_o),
    .status_o             (status_o),
    .frame_released_o     (frame_released_o)
  );

  frt_checker refcount_check (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_frames_managed_i (cfg_frames_managed_i),
    .in_valid_i           (in_valid_i),
    .in_ready_i           (in_ready_o),
    .action_i             (action_i),
    .address_i            (address_i),
    .end_address_i        (end_address_i),
    .out_valid_i          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .count_i              (count_o),
    .status_i             (status_o),
    .frame_released_i     (frame_released_o),
    .outstanding_o        (outstanding),
    .mismatches_o         (mismatches)
  );

  always #10 clk_i = ~clk_i;

  initial begin : time_limit
    #20_000_000;
    $display("** frame_refcount_table_unit: FAILED **");
    $finish;
  end

  // Result side: bursts of ready and of stall, plus one long hold-off on request.
  initial begin : result_side
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  task automatic send_word(input logic [2:0] act, input logic [ADDR_W-1:0] addr,
                           input logic [ADDR_W-1:0] end_addr);
    in_valid_i    <= 1'b1;
    action_i      <= act;
    address_i     <= addr;
    end_address_i <= end_addr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic pause(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_frames_managed(input int unsigned value);
    cfg_we_i             <= 1'b1;
    cfg_frames_managed_i <= CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    frames_now = (value < FRAME_COUNT_DEF) ? value : FRAME_COUNT_DEF;
  endtask

  // Mostly the first few frames, so that counts are claimed, shared and freed again;
  // sometimes anywhere up to just past the limit, sometimes a fully random address.
  function automatic logic [ADDR_W-1:0] pick_address(input int unsigned lim);
    int unsigned sel;
    int unsigned frame;
    sel = $urandom_range(0, 99);
    if (sel < 10) return $urandom;
    if (sel < 75) frame = $urandom_range(0, ((lim < 16) ? lim : 16) + 1);
    else frame = $urandom_range(0, lim + 1);
    return (ADDR_W'(frame) << PAGE_SHIFT_DEF) | ADDR_W'($urandom_range(0, PAGE_MASK));
  endfunction

  task automatic random_word(input int unsigned lim);
    int unsigned       pick;
    logic [2:0]        act;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] end_addr;
    logic [ADDR_W:0]   span;
    pick     = $urandom_range(0, 99);
    addr     = pick_address(lim);
    end_addr = $urandom;
    if (pick < 24) begin
      act = ACT_CLAIM;
    end else if (pick < 50) begin
      act = ACT_RELEASE;
    end else if (pick < 68) begin
      act = ACT_ADDREF;
    end else if (pick < 80) begin
      act = ACT_READ;
    end else if (pick < 96) begin
      act  = ACT_RESERVE;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        end_addr = (addr == '0) ? '0 : ADDR_W'($urandom_range(0, addr - 1));
      end else if (pick < 14) begin
        end_addr = addr;
      end else if (pick < 19) begin
        end_addr = '1;
      end else begin
        span = {1'b0, addr} + (33'($urandom_range(0, 24)) << PAGE_SHIFT_DEF)
               + 33'($urandom_range(0, PAGE_MASK));
        end_addr = span[ADDR_W] ? '1 : span[ADDR_W-1:0];
      end
    end else begin
      // Codes above reserve are not actions and must leave the table alone.
      act = ACT_RESERVE + 3'($urandom_range(1, 3));
    end
    send_word(act, addr, end_addr);
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // With the register at its reset value nothing is managed.
    send_word(ACT_CLAIM, 32'h0000_0000, $urandom);
    send_word(ACT_RESERVE, 32'h0000_0000, 32'h0000_2000);
    wait_drained();

    write_frames_managed(FRAME_COUNT_DEF);
    send_word(ACT_CLAIM, 32'h0000_0000, $urandom);
    send_word(ACT_CLAIM, 32'h0000_0FFF, $urandom);
    send_word(ACT_ADDREF, 32'h0000_0800, $urandom);
    send_word(ACT_READ, 32'h0000_0123, $urandom);
    send_word(ACT_RELEASE, 32'h0000_0000, $urandom);
    send_word(ACT_RELEASE, 32'h0000_0FFF, $urandom);
    send_word(ACT_RELEASE, 32'h0000_0000, $urandom);
    send_word(ACT_ADDREF, 32'h0000_0000, $urandom);
    send_word(ACT_READ, 32'h00FF_FFFF, $urandom);
    send_word(ACT_CLAIM, 32'h00FF_F000, $urandom);
    send_word(ACT_CLAIM, 32'h0100_0000, $urandom);
    send_word(ACT_RELEASE, 32'hFFFF_FFFF, $urandom);
    send_word(ACT_ADDREF, 32'h8000_0000, $urandom);
    send_word(ACT_READ, 32'h0100_0FFF, $urandom);
    send_word(ACT_RESERVE, 32'h0000_5000, 32'h0000_4FFF);
    send_word(ACT_RESERVE, 32'h0000_5000, 32'h0000_5000);
    send_word(ACT_RESERVE, 32'h0000_3001, 32'h0000_6001);
    send_word(ACT_READ, 32'h0000_6000, $urandom);
    send_word(ACT_READ, 32'h0000_7000, $urandom);
    // Runs to the very top of the address space; the table end clamps it.
    send_word(ACT_RESERVE, 32'h00FF_0000, 32'hFFFF_FFFF);
    send_word(ACT_ADDREF, 32'h00FF_F000, $urandom);
    send_word(ACT_RESERVE, 32'hFFFF_F000, 32'hFFFF_FFFF);
    send_word(ACT_RESERVE + 3'd1, $urandom, $urandom);
    send_word(ACT_RESERVE + 3'd2, $urandom, $urandom);
    send_word(ACT_RESERVE + 3'd3, $urandom, $urandom);
    wait_drained();

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      write_frames_managed(FRAME_PLAN[phase]);
      idle_on = (phase != PHASES - 1);
      for (int unsigned n = 0; n < WORDS_PER_PHASE; n++) begin
        if (phase == 1 && n == 40) hold_req = 1'b1;
        if (phase == 3 && n == 60) wait_drained();
        if (idle_on && $urandom_range(0, 3) == 0) pause($urandom_range(1, 9));
        random_word(frames_now);
      end
      wait_drained();
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0) begin
      $display("** frame_refcount_table_unit: PASSED **");
    end else begin
      $display("** frame_refcount_table_unit: FAILED **");
    end
    $finish;
  end

endmodule
